// ===== hdl/tea_block_cipher_unit_macros.svh =====
// Assertion macros shared by the cipher RTL.
`ifndef TEA_BLOCK_CIPHER_UNIT_MACROS_SVH
`define TEA_BLOCK_CIPHER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define TEA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Implication from an antecedent to a consequent in the next cycle.
`define TEA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TEA_ASSERT(label, clk, rst_n, prop, msg)
`define TEA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== hdl/tea_pkg.sv =====
`default_nettype none

package tea_pkg;

    // Number of full cipher cycles; each one is split over two cells.
    localparam int ROUNDS = 32;
    localparam int CELLS  = 2 * ROUNDS;

    localparam logic [31:0] DELTA = 32'h9E37_79B9;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        KEY_WORD0 = 2'd0,
        KEY_WORD1 = 2'd1,
        KEY_WORD2 = 2'd2,
        KEY_WORD3 = 2'd3
    } key_idx_t;

    // The 128-bit key as four words.
    typedef struct packed {
        logic [31:0] k3;
        logic [31:0] k2;
        logic [31:0] k1;
        logic [31:0] k0;
    } key_t;

    // One block travelling down the cell chain.
    typedef struct packed {
        logic        mode;
        logic [31:0] v_high;
        logic [31:0] v_low;
    } item_t;

    // Running sum used by an encrypt cycle (delta added before the cycle).
    function automatic logic [31:0] enc_sum(input int r);
        logic [63:0] p;
        p = 64'(DELTA) * 64'(r + 1);
        return p[31:0];
    endfunction

    // Running sum used by a decrypt cycle (delta removed after the cycle).
    function automatic logic [31:0] dec_sum(input int r);
        logic [63:0] p;
        p = 64'(DELTA) * 64'(ROUNDS - r);
        return p[31:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/tea_key_regs.sv =====
`default_nettype none

`include "tea_block_cipher_unit_macros.svh"

module tea_key_regs (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire tea_pkg::key_idx_t     cfg_index,
    input  wire logic [31:0]           cfg_data,
    output tea_pkg::key_t              key
);

    tea_pkg::key_t key_reg;
    tea_pkg::key_t key_next;

    // Decode the register index and update one key word.
    always_comb
    begin
        key_next = key_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                tea_pkg::KEY_WORD0: key_next.k0 = cfg_data;
                tea_pkg::KEY_WORD1: key_next.k1 = cfg_data;
                tea_pkg::KEY_WORD2: key_next.k2 = cfg_data;
                tea_pkg::KEY_WORD3: key_next.k3 = cfg_data;
                default:            key_next = key_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else
        begin
            key_reg <= key_next;
        end
    end

    assign key = key_reg;

    `TEA_ASSERT_NEXT(a_k0_write, clk, rst_n, cfg_we && cfg_index == tea_pkg::KEY_WORD0,
        key_reg.k0 == $past(cfg_data), "key word 0 not written")
    `TEA_ASSERT_NEXT(a_k3_write, clk, rst_n, cfg_we && cfg_index == tea_pkg::KEY_WORD3,
        key_reg.k3 == $past(cfg_data), "key word 3 not written")
    `TEA_ASSERT_NEXT(a_key_hold, clk, rst_n, !cfg_we, $stable(key_reg),
        "key changed without a write")

endmodule

`default_nettype wire

// ===== hdl/tea_round_cell.sv =====
`default_nettype none

`include "tea_block_cipher_unit_macros.svh"

// One half of a cipher cycle: updates one word of the block from the other.
module tea_round_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tea_pkg::key_t     key,
    input  wire logic              phase,
    input  wire logic [31:0]       sum_enc,
    input  wire logic [31:0]       sum_dec,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire tea_pkg::item_t    in_item,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output tea_pkg::item_t         out_item
);

    logic           valid_reg;
    logic           valid_next;
    tea_pkg::item_t item_reg;
    tea_pkg::item_t item_next;

    logic        upd_high;
    logic [31:0] src;
    logic [31:0] tgt;
    logic [31:0] ka;
    logic [31:0] kb;
    logic [31:0] sum;
    logic [31:0] mix;
    logic [31:0] res;
    logic        load;

    // Encrypt updates the high word first, decrypt the low word first.
    assign upd_high = ~(phase ^ in_item.mode);
    assign src      = upd_high ? in_item.v_low  : in_item.v_high;
    assign tgt      = upd_high ? in_item.v_high : in_item.v_low;
    assign ka       = upd_high ? key.k0 : key.k2;
    assign kb       = upd_high ? key.k1 : key.k3;
    assign sum      = in_item.mode ? sum_dec : sum_enc;

    // Mixing function and the add or subtract into the target word.
    assign mix = ((src << 4) + ka) ^ (src + sum) ^ ((src >> 5) + kb);
    assign res = in_item.mode ? (tgt - mix) : (tgt + mix);

    // The cell takes a new request when empty or when its content moves on.
    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        item_next      = in_item;
        if (upd_high)
        begin
            item_next.v_high = res;
        end
        else
        begin
            item_next.v_low = res;
        end
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    `TEA_ASSERT(a_ready_empty, clk, rst_n, valid_reg || in_ready,
        "empty cell refuses a request")
    `TEA_ASSERT_NEXT(a_mode_kept, clk, rst_n, load, item_reg.mode == $past(in_item.mode),
        "mode bit altered in cell")
    `TEA_ASSERT_NEXT(a_other_word, clk, rst_n, load && upd_high,
        item_reg.v_low == $past(in_item.v_low), "source word altered in cell")

endmodule

`default_nettype wire

// ===== hdl/tea_block_cipher_unit.sv =====
`default_nettype none

// TEA 64-bit block cipher, encrypt or decrypt per block with a 128-bit key held
// in four 32-bit registers written through the cfg port. Blocks flow through a
// chain of 64 cells, each doing one half of a cipher cycle, and one block per
// cycle is accepted while the output is not stalled; an empty cell ahead of a
// stalled output still takes new blocks. The key must only be written while
// no block is in the chain.
module tea_block_cipher_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    // Input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,  // block_high [31:0], block_low [63:32]
    input  wire logic        s_axis_tuser,  // opcode [0]
    // Output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata   // result_high [31:0], result_low [63:32]
);

    tea_pkg::key_t  key;
    logic           valid_chain [tea_pkg::CELLS + 1];
    logic           ready_chain [tea_pkg::CELLS + 1];
    tea_pkg::item_t item_chain  [tea_pkg::CELLS + 1];

    tea_key_regs u_key_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (tea_pkg::key_idx_t'(cfg_index)),
        .cfg_data  (cfg_data),
        .key       (key)
    );

    // Input request enters the first cell.
    assign valid_chain[0]        = s_axis_tvalid;
    assign s_axis_tready         = ready_chain[0];
    assign item_chain[0].mode    = s_axis_tuser;
    assign item_chain[0].v_high  = s_axis_tdata[31:0];
    assign item_chain[0].v_low   = s_axis_tdata[63:32];

    // Chain of half-cycle cells.
    for (genvar i = 0; i < tea_pkg::CELLS; i++)
    begin : g_cell
        tea_round_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .key       (key),
            .phase     (1'(i % 2)),
            .sum_enc   (tea_pkg::enc_sum(i / 2)),
            .sum_dec   (tea_pkg::dec_sum(i / 2)),
            .in_valid  (valid_chain[i]),
            .in_ready  (ready_chain[i]),
            .in_item   (item_chain[i]),
            .out_valid (valid_chain[i + 1]),
            .out_ready (ready_chain[i + 1]),
            .out_item  (item_chain[i + 1])
        );
    end

    // The last cell register is the output stage.
    assign ready_chain[tea_pkg::CELLS] = m_axis_tready;
    assign m_axis_tvalid               = valid_chain[tea_pkg::CELLS];
    assign m_axis_tdata = {item_chain[tea_pkg::CELLS].v_low, item_chain[tea_pkg::CELLS].v_high};

endmodule

`default_nettype wire
